// ===== sv/tplk_pkg.sv =====
// Shared types, constants and the entry ordering function of the lock arbiter.
package tplk_pkg;

  localparam int STAMP_W  = 32;
  localparam int CLIENT_W = 3;
  localparam int SERVER_W = 8;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Operation codes of a command word.
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_SERVER_ID = 1'b0;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic [CLIENT_W-1:0] client;
  } entry_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    entry_t entry;
    logic   occ;
    logic   lt;
    logic   hole;
  } cell_link_t;

  // Broadcast command to all cells.
  typedef struct packed {
    logic purge;
    logic insert;
    logic compact;
    logic pop;
  } cell_ctrl_t;

  // True when entry a is served before entry b: lower stamp, then lower client.
  function automatic logic serves_first(entry_t a, entry_t b);
    logic [STAMP_W+CLIENT_W-1:0] ka;
    logic [STAMP_W+CLIENT_W-1:0] kb;
    ka = {a.stamp, a.client};
    kb = {b.stamp, b.client};
    return ka < kb;
  endfunction

endpackage

// ===== sv/tplk_if.sv =====
// Command and result channel interfaces of the lock arbiter.
interface tplk_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [tplk_pkg::CLIENT_W-1:0] client_id;
  logic [tplk_pkg::STAMP_W-1:0]  time_stamp;

  modport source(output valid, output op, output client_id, output time_stamp, input ready);
  modport sink(input valid, input op, input client_id, input time_stamp, output ready);
endinterface

interface tplk_res_if;
  logic                          valid;
  logic                          ready;
  logic                          grant_valid;
  logic [tplk_pkg::CLIENT_W-1:0] grant_client;
  logic [tplk_pkg::STAMP_W-1:0]  grant_stamp;
  logic [tplk_pkg::SERVER_W-1:0] grant_server;
  logic                          request_dropped;
  logic                          lock_held;

  modport source(output valid, output grant_valid, output grant_client, output grant_stamp,
                 output grant_server, output request_dropped, output lock_held, input ready);
  modport sink(input valid, input grant_valid, input grant_client, input grant_stamp,
               input grant_server, input request_dropped, input lock_held, output ready);
endinterface

// ===== sv/timestamp_priority_lock_arbiter.sv =====
// Top level of the timestamp priority lock arbiter: sequencer, cell chain, APB register.
//
//   channel  dir  handshake            payload
//   cmd      in   valid/ready          op, client_id, time_stamp
//   result   out  valid/ready          grant_valid, grant_client, grant_stamp,
//                                      grant_server, request_dropped, lock_held
//   apb      in   psel/penable/pready  paddr, pwdata, pwrite -> prdata
//
// A request passes through accept and finish. A release passes through accept,
// purge, compaction check and finish, and the compaction check repeats a
// shift of the cell chain while any purged entry sits ahead of a surviving
// entry. The finish step waits while the result register still holds an
// untaken word; a new command word is taken as soon as the sequencer is back
// in idle. Reset empties the chain and frees the lock.
module timestamp_priority_lock_arbiter #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  tplk_cmd_if.sink                      cmd,
  tplk_res_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tplk_pkg::ADDR_W-1:0]   paddr,
  input  logic [tplk_pkg::DATA_W-1:0]   pwdata,
  output logic [tplk_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PURGE   = 4'b0010,
    ST_COMPACT = 4'b0100,
    ST_FINISH  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Held command word.
  logic                          item_op;
  logic [tplk_pkg::CLIENT_W-1:0] item_client;
  logic [tplk_pkg::STAMP_W-1:0]  item_stamp;
  tplk_pkg::entry_t              item_entry;

  logic                          lock_busy;
  logic                          lock_next;
  logic [tplk_pkg::SERVER_W-1:0] server_id;

  // Result register.
  logic                          res_valid;
  logic                          res_grant_valid;
  logic [tplk_pkg::CLIENT_W-1:0] res_grant_client;
  logic [tplk_pkg::STAMP_W-1:0]  res_grant_stamp;
  logic [tplk_pkg::SERVER_W-1:0] res_grant_server;
  logic                          res_dropped;
  logic                          res_lock_held;

  logic                 out_free;
  logic                 load;
  logic                 gv;
  logic                 dropped;
  tplk_pkg::entry_t     grant_entry;
  tplk_pkg::cell_ctrl_t ctrl;
  logic                 cfg_write;

  // Cell chain.
  tplk_pkg::cell_link_t             link [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]           gap_vec;
  tplk_pkg::cell_link_t             head_link;
  tplk_pkg::cell_link_t             tail_link;
  logic                             full;
  logic                             any_gap;

  assign item_entry.stamp  = item_stamp;
  assign item_entry.client = item_client;

  // Boundary links: nothing sorts ahead of the head, nothing sits past the tail.
  assign head_link.entry = '0;
  assign head_link.occ   = 1'b1;
  assign head_link.lt    = 1'b0;
  assign head_link.hole  = 1'b0;
  assign tail_link.entry = '0;
  assign tail_link.occ   = 1'b0;
  assign tail_link.lt    = 1'b1;
  assign tail_link.hole  = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tplk_pkg::cell_link_t left_l;
    tplk_pkg::cell_link_t right_l;
    if (i == 0) begin : g_first
      assign left_l = head_link;
    end else begin : g_mid_l
      assign left_l = link[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_l = tail_link;
    end else begin : g_mid_r
      assign right_l = link[i+1];
    end
    tplk_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_entry    (item_entry),
      .purge_client (item_client),
      .left         (left_l),
      .right        (right_l),
      .link         (link[i]),
      .gap          (gap_vec[i])
    );
  end

  // The chain stays packed toward the head, so the tail flag means full.
  assign full    = link[QUEUE_DEPTH-1].occ;
  assign any_gap = |gap_vec;

  assign cmd.ready = (state == ST_IDLE);
  assign out_free  = ~res_valid | result.ready;

  // Sequencer: decide the cell command and the result of the held word.
  always_comb begin
    state_next  = state;
    ctrl        = '0;
    lock_next   = lock_busy;
    load        = 1'b0;
    gv          = 1'b0;
    dropped     = 1'b0;
    grant_entry = '0;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          state_next = (cmd.op == tplk_pkg::OP_RELEASE) ? ST_PURGE : ST_FINISH;
        end
      end
      ST_PURGE: begin
        // free the lock and drop every waiting entry of the releasing client
        ctrl.purge = 1'b1;
        lock_next  = 1'b0;
        state_next = ST_COMPACT;
      end
      ST_COMPACT: begin
        // close one hole per cycle until the occupied cells form a prefix
        if (any_gap) begin
          ctrl.compact = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
          if (item_op == tplk_pkg::OP_REQUEST) begin
            if (!lock_busy) begin
              gv          = 1'b1;
              grant_entry = item_entry;
              lock_next   = 1'b1;
            end else if (!full) begin
              ctrl.insert = 1'b1;
            end else begin
              dropped = 1'b1;
            end
          end else if (link[0].occ) begin
            // head holds the best waiting entry: grant it and advance the chain
            gv          = 1'b1;
            grant_entry = link[0].entry;
            ctrl.pop    = 1'b1;
            lock_next   = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lock_busy <= 1'b0;
      server_id <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lock_busy <= lock_next;
      if (cfg_write && paddr[2] == tplk_pkg::REG_SERVER_ID) begin
        server_id <= pwdata[tplk_pkg::SERVER_W-1:0];
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Payload registers: hold the command word and the result word.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item_op     <= cmd.op;
      item_client <= cmd.client_id;
      item_stamp  <= cmd.time_stamp;
    end
    if (load) begin
      res_grant_valid  <= gv;
      res_grant_client <= grant_entry.client;
      res_grant_stamp  <= grant_entry.stamp;
      res_grant_server <= gv ? server_id : '0;
      res_dropped      <= dropped;
      res_lock_held    <= lock_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.grant_valid     = res_grant_valid;
  assign result.grant_client    = res_grant_client;
  assign result.grant_stamp     = res_grant_stamp;
  assign result.grant_server    = res_grant_server;
  assign result.request_dropped = res_dropped;
  assign result.lock_held       = res_lock_held;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tplk_pkg::REG_SERVER_ID) ?
                  {{(tplk_pkg::DATA_W - tplk_pkg::SERVER_W){1'b0}}, server_id} : '0;

endmodule

// ===== sv/tplk_cell.sv =====
// One cell of the sorted wait chain: holds one entry and its occupied flag.
module tplk_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  tplk_pkg::cell_ctrl_t          ctrl,
  input  tplk_pkg::entry_t              new_entry,
  input  logic [tplk_pkg::CLIENT_W-1:0] purge_client,
  input  tplk_pkg::cell_link_t          left,
  input  tplk_pkg::cell_link_t          right,
  output tplk_pkg::cell_link_t          link,
  output logic                          gap
);

  tplk_pkg::entry_t entry;
  tplk_pkg::entry_t entry_next;
  logic             occ;
  logic             occ_next;
  logic             hole;
  logic             lt;
  logic             shift;

  assign hole  = left.hole | ~occ;
  assign lt    = ~occ | tplk_pkg::serves_first(new_entry, entry);
  assign gap   = left.hole & occ;
  assign shift = ctrl.pop | (ctrl.compact & hole);

  always_comb begin
    entry_next = entry;
    occ_next   = occ;
    if (ctrl.purge) begin
      occ_next = occ & (entry.client != purge_client);
    end else if (ctrl.insert) begin
      if (lt) begin
        // first cell past the new word takes it, later cells take the left word
        if (!left.lt) begin
          entry_next = new_entry;
          occ_next   = 1'b1;
        end else begin
          entry_next = left.entry;
          occ_next   = left.occ;
        end
      end
    end else if (shift) begin
      entry_next = right.entry;
      occ_next   = right.occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign link.entry = entry;
  assign link.occ   = occ;
  assign link.lt    = lt;
  assign link.hole  = hole;

endmodule

// ===== sv/tplk_checker.sv =====
// Port-level checks of the lock arbiter, bound to the top level.
module tplk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          grant_valid,
  input logic [tplk_pkg::CLIENT_W-1:0] grant_client,
  input logic [tplk_pkg::STAMP_W-1:0]  grant_stamp,
  input logic [tplk_pkg::SERVER_W-1:0] grant_server,
  input logic                          request_dropped,
  input logic                          lock_held
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(grant_stamp) && $stable(grant_client))
    else $error("result word changed while stalled");

  a_grant_locks: assert property (@(posedge clk) disable iff (rst)
    res_valid && grant_valid |-> lock_held)
    else $error("grant without lock held");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !grant_valid |-> grant_client == '0 && grant_stamp == '0 && grant_server == '0)
    else $error("grant fields not cleared without grant");

  a_drop_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && request_dropped |-> !grant_valid && lock_held)
    else $error("drop while lock free or granted");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind timestamp_priority_lock_arbiter tplk_checker u_tplk_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .grant_valid     (result.grant_valid),
  .grant_client    (result.grant_client),
  .grant_stamp     (result.grant_stamp),
  .grant_server    (result.grant_server),
  .request_dropped (result.request_dropped),
  .lock_held       (result.lock_held)
);

// ===== bench/timestamp_priority_lock_arbiter_test.sv =====
// Self-checking bench for the timestamp priority lock arbiter: directed and random lock traffic.
module timestamp_priority_lock_arbiter_test;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PHASE_WORDS  = 250;
  localparam int DRAIN_PERIOD = 97;   // every so often, hold off until all grants are back

  // One command word as queued for the driver.
  typedef struct {
    logic                          op;
    logic [tplk_pkg::CLIENT_W-1:0] client;
    logic [tplk_pkg::STAMP_W-1:0]  stamp;
    bit                            by_holder;   // release issued by the current lock holder
  } lock_cmd_t;

  // One result word, in port order.
  typedef struct packed {
    logic                          grant_valid;
    logic [tplk_pkg::CLIENT_W-1:0] grant_client;
    logic [tplk_pkg::STAMP_W-1:0]  grant_stamp;
    logic [tplk_pkg::SERVER_W-1:0] grant_server;
    logic                          request_dropped;
    logic                          lock_held;
  } grant_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [tplk_pkg::ADDR_W-1:0] paddr = '0;
  logic [tplk_pkg::DATA_W-1:0] pwdata = '0;
  logic [tplk_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  tplk_cmd_if cmd_ch();
  tplk_res_if res_ch();

  timestamp_priority_lock_arbiter #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the arbiter: lock state, waiting line and the server id register.
  logic                          lock_taken = 1'b0;
  logic [tplk_pkg::CLIENT_W-1:0] lock_owner = '0;
  tplk_pkg::entry_t              waiters[$];
  logic [tplk_pkg::SERVER_W-1:0] server_copy = '0;

  grant_word_t grants_due[$];   // expected result words, oldest first
  lock_cmd_t   pending[$];      // command words not yet sent
  int          fail_count = 0;

  // Print one line and count when a field disagrees.
  task automatic flag_mismatch(string what, logic [tplk_pkg::STAMP_W-1:0] got,
                               logic [tplk_pkg::STAMP_W-1:0] want);
    if (got !== want) begin
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
    end
  endtask

  // Apply one command to the shadow state and return the word it must produce.
  function automatic grant_word_t arbitrate(logic op, logic [tplk_pkg::CLIENT_W-1:0] client,
                                            logic [tplk_pkg::STAMP_W-1:0] cmd_stamp);
    grant_word_t      w;
    tplk_pkg::entry_t kept[$];
    int               best;
    w = '0;
    if (op == tplk_pkg::OP_REQUEST) begin
      if (!lock_taken) begin
        // lock free: grant on the spot
        w.grant_valid  = 1'b1;
        w.grant_client = client;
        w.grant_stamp  = cmd_stamp;
        lock_taken     = 1'b1;
        lock_owner     = client;
      end else if (waiters.size() < QUEUE_DEPTH) begin
        waiters.push_back('{stamp: cmd_stamp, client: client});
      end else begin
        w.request_dropped = 1'b1;
      end
    end else begin
      // release: free the lock whoever asks, drop the client's waiters, hand to the best
      lock_taken = 1'b0;
      foreach (waiters[i]) begin
        if (waiters[i].client != client) kept.push_back(waiters[i]);
      end
      waiters = kept;
      if (waiters.size() > 0) begin
        best = 0;
        for (int i = 1; i < waiters.size(); i++) begin
          if ({waiters[i].stamp, waiters[i].client} <
              {waiters[best].stamp, waiters[best].client}) best = i;
        end
        w.grant_valid  = 1'b1;
        w.grant_client = waiters[best].client;
        w.grant_stamp  = waiters[best].stamp;
        waiters.delete(best);
        lock_taken = 1'b1;
        lock_owner = w.grant_client;
      end
    end
    if (w.grant_valid) w.grant_server = server_copy;
    w.lock_held = lock_taken;
    return w;
  endfunction

  // Driver: bursts of words with random gaps, holding each word until it is taken.
  int burst_left = 0;
  int gap_left   = 0;
  int words_sent = 0;
  bit cmd_fire   = 1'b0;   // word on the channel was taken at the last rising edge

  always @(negedge clk) begin
    lock_cmd_t nxt;
    logic      drive;
    drive = cmd_ch.valid && !cmd_fire;   // hold an untaken word
    if (!rst && !drive) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0 &&
                   !(words_sent % DRAIN_PERIOD == DRAIN_PERIOD - 1 && grants_due.size() > 0)) begin
        nxt = pending.pop_front();
        // steer a well-formed release to the current holder
        if (nxt.by_holder && lock_taken) nxt.client = lock_owner;
        cmd_ch.op         <= nxt.op;
        cmd_ch.client_id  <= nxt.client;
        cmd_ch.time_stamp <= nxt.stamp;
        drive = 1'b1;
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    cmd_ch.valid <= drive;
  end

  // Receiver: ready follows a randomly drawn stall mode.
  logic [31:0] stall_pattern = '1;
  int          stall_phase   = 0;
  int          stall_mode    = 0;

  always @(negedge clk) begin
    if (stall_phase % 150 == 0) begin
      stall_mode    = $urandom_range(0, 3);
      stall_pattern = ($urandom_range(0, 1) != 0) ? $urandom : ($urandom & $urandom);
    end
    stall_phase++;
    case (stall_mode)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= stall_pattern[stall_phase % 32];
      2:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      default: res_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Monitor: check each taken result word, then predict for each taken command word.
  always @(posedge clk) begin
    grant_word_t got;
    grant_word_t want;
    cmd_fire <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.grant_valid, res_ch.grant_client, res_ch.grant_stamp,
             res_ch.grant_server, res_ch.request_dropped, res_ch.lock_held};
      if (grants_due.size() == 0) begin
        flag_mismatch("result word with no command outstanding", 32'd1, 32'd0);
      end else begin
        want = grants_due.pop_front();
        flag_mismatch("grant_valid", 32'(got.grant_valid), 32'(want.grant_valid));
        flag_mismatch("grant_client", 32'(got.grant_client), 32'(want.grant_client));
        flag_mismatch("grant_stamp", got.grant_stamp, want.grant_stamp);
        flag_mismatch("grant_server", 32'(got.grant_server), 32'(want.grant_server));
        flag_mismatch("request_dropped", 32'(got.request_dropped), 32'(want.request_dropped));
        flag_mismatch("lock_held", 32'(got.lock_held), 32'(want.lock_held));
      end
    end
    if (!rst && cmd_ch.valid && cmd_ch.ready)
      grants_due.push_back(arbitrate(cmd_ch.op, cmd_ch.client_id, cmd_ch.time_stamp));
  end

  task automatic queue_cmd(logic op, logic [tplk_pkg::CLIENT_W-1:0] client,
                           logic [tplk_pkg::STAMP_W-1:0] stamp);
    pending.push_back('{op: op, client: client, stamp: stamp, by_holder: 1'b0});
  endtask

  // Random traffic in segments that fill, churn or drain the waiting line.
  task automatic queue_traffic(int count);
    lock_cmd_t                    c;
    int                           seg_left;
    int                           req_odds;
    logic [tplk_pkg::STAMP_W-1:0] stamp_clock;
    seg_left    = 0;
    req_odds    = 50;
    stamp_clock = $urandom;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        case ($urandom_range(0, 2))
          0:       req_odds = 85;   // push toward a full line and drops
          1:       req_odds = 55;
          default: req_odds = 25;   // drain
        endcase
      end
      seg_left--;
      c.op        = ($urandom_range(0, 99) < req_odds) ? tplk_pkg::OP_REQUEST :
                                                         tplk_pkg::OP_RELEASE;
      c.client    = tplk_pkg::CLIENT_W'($urandom_range(0, 7));
      c.by_holder = (c.op == tplk_pkg::OP_RELEASE) && ($urandom_range(0, 9) < 7);
      case ($urandom_range(0, 3))
        0: c.stamp = $urandom_range(0, 7);   // crowd the ties
        1: c.stamp = $urandom;
        2: begin
          // Lamport-style clock, wraps through the top of the range
          stamp_clock = stamp_clock + $urandom_range(0, 3);
          c.stamp     = stamp_clock;
        end
        default: c.stamp = (($urandom_range(0, 1) != 0) ? 32'hFFFF_FFF0 : 32'h0000_0000) |
                           $urandom_range(0, 15);
      endcase
      pending.push_back(c);
    end
  endtask

  // Block until every word is sent and every result is back.
  task automatic wait_drained();
    while (pending.size() > 0 || cmd_ch.valid || grants_due.size() > 0) @(posedge clk);
  endtask

  // Write server_id over APB, mirror it, and read it back.
  task automatic program_server_id(logic [tplk_pkg::SERVER_W-1:0] id);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {tplk_pkg::REG_SERVER_ID, 2'b00};
    pwdata  <= tplk_pkg::DATA_W'(id);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    server_copy = id;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    flag_mismatch("server_id read-back", 32'(prdata[tplk_pkg::SERVER_W-1:0]), 32'(id));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = tplk_pkg::OP_REQUEST;
    cmd_ch.client_id  = '0;
    cmd_ch.time_stamp = '0;
    res_ch.ready      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with server_id still at its reset value.
    queue_cmd(tplk_pkg::OP_RELEASE, 3'd0, 32'hDEAD_BEEF);   // release while free: no grant
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd5, 32'hFFFF_FFFF);   // free lock: immediate grant
    // sixteen waiters: ties on stamp, duplicates of one client, extremes
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd3, 32'd5);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd1, 32'd5);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd3, 32'd0);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd7, 32'd0);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd2, 32'hFFFF_FFFF);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd2, 32'hFFFF_FFFF);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd6, 32'h8000_0000);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd4, 32'h7FFF_FFFF);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd0, 32'd1);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd2, 32'd3);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd5, 32'd2);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd1, 32'hFFFF_FFFE);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd7, 32'h5555_5555);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd0, 32'hAAAA_AAAA);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd4, 32'd0);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd6, 32'd0);
    queue_cmd(tplk_pkg::OP_REQUEST, 3'd6, 32'd1);           // line full: dropped
    queue_cmd(tplk_pkg::OP_RELEASE, 3'd2, 32'h1234_5678);   // not the holder: purge, hand over
    queue_cmd(tplk_pkg::OP_RELEASE, 3'd3, 32'hFFFF_FFFF);   // holder releases, own waiters purged
    queue_cmd(tplk_pkg::OP_RELEASE, 3'd4, 32'd0);
    wait_drained();

    // Random phases across server_id settings, extremes included.
    program_server_id(8'hFF);
    queue_traffic(PHASE_WORDS);
    wait_drained();
    program_server_id(8'h00);
    queue_traffic(PHASE_WORDS);
    wait_drained();
    program_server_id(8'($urandom_range(1, 254)));
    queue_traffic(PHASE_WORDS);
    wait_drained();

    // let any stray word show up before closing
    repeat (40) @(posedge clk);
    flag_mismatch("result words never returned", 32'(grants_due.size()), 32'd0);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
